FILE: design/ttx_time_pkg.sv
`default_nettype none

package ttx_time_pkg;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_DAY    = 3'd1,
        ST_BAD_TIME   = 3'd2,
        ST_BEYOND_DAY = 3'd3,
        ST_ZONE_RANGE = 3'd4
    } status_t;

    localparam int MJD_UNIX_EPOCH  = 40587;
    localparam int SECONDS_PER_DAY = 86400;
    localparam int SECS_PER_HOUR   = 3600;
    localparam int SECS_PER_MINUTE = 60;
    localparam int SECS_PER_COUNT  = 900;
    localparam int HOURS_PER_DAY   = 24;
    localparam int ZONE_COUNT_MAX  = 48;
    localparam int ZONE_LIMIT      = 43200;
    localparam int ZONE_WEST_BIT   = 6;
    localparam logic [7:0] ZONE_COUNT_MASK = 8'h3E;

    localparam logic [3:0] DIGIT_MAX_DEC = 4'd9;
    localparam logic [3:0] DIGIT_MAX_HT  = 4'd2;
    localparam logic [3:0] DIGIT_MAX_MS  = 4'd5;

    // nibble carries digit + 1; zero or above max + 1 is bad
    function automatic logic digit_ok(input logic [3:0] nib, input logic [3:0] max_digit);
        digit_ok = (nib != 4'd0) && ((nib - 4'd1) <= max_digit);
    endfunction

    function automatic logic [3:0] digit_of(input logic [3:0] nib);
        digit_of = nib - 4'd1;
    endfunction

endpackage

`default_nettype wire

FILE: design/teletext_time_packet_decode.sv
// Teletext time packet decoder, four register stages.
// An accepted item passes through stages 1, 2, 3 and 4 in order; out_valid is the stage 4 valid.
// Throughput: one item per cycle while out_stall is low; the output stage is a
// register, so an item moves forward into any empty stage while the result waits at the output.
// Reset (rst_n low, asynchronous) empties all stages; payload is not reset.
`default_nettype none

module teletext_time_packet_decode (
    input  wire  logic                 clk,
    input  wire  logic                 rst_n,
    input  wire  logic                 in_valid,
    output logic                       in_stall,
    input  wire  logic [7:0]           zone_byte,
    input  wire  logic [7:0]           day_top,
    input  wire  logic [7:0]           day_mid,
    input  wire  logic [7:0]           day_low,
    input  wire  logic [7:0]           hour_byte,
    input  wire  logic [7:0]           minute_byte,
    input  wire  logic [7:0]           second_byte,
    output logic                       out_valid,
    input  wire  logic                 out_stall,
    output logic [2:0]                 status,
    output logic signed [33:0]         epoch_seconds,
    output logic signed [16:0]         zone_offset
);
    import ttx_time_pkg::*;

    // stage valids and advance enables
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    // stage 1: digit checks and decimal values
    status_t     st1_reg, st1_next;
    logic [16:0] mjd1_reg, mjd1_next;
    logic [4:0]  hours1_reg, hours1_next;
    logic [5:0]  mins1_reg, mins1_next;
    logic [5:0]  secs1_reg, secs1_next;
    logic [5:0]  count1_reg, count1_next;
    logic        west1_reg, west1_next;

    // stage 2: day offset, time of day, zone offset
    status_t            st2_reg, st2_next;
    logic signed [17:0] dday2_reg, dday2_next;
    logic [16:0]        tod2_reg, tod2_next;
    logic signed [16:0] zone2_reg, zone2_next;

    // stage 3: day seconds product
    status_t            st3_reg;
    logic signed [34:0] prod3_reg, prod3_next;
    logic [16:0]        tod3_reg;
    logic signed [16:0] zone3_reg;

    // stage 4: output
    status_t            st4_reg;
    logic signed [33:0] epoch4_reg, epoch4_next;
    logic signed [16:0] zone4_reg, zone4_next;

    assign adv4     = !v4_reg || !out_stall;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_stall = !adv1;

    always_comb
    begin
        logic [3:0] d0, d1, d2, d3, d4, t0, t1, t2, t3, t4, t5;
        logic       day_good, time_good;
        d0 = day_top[3:0];
        d1 = day_mid[7:4];
        d2 = day_mid[3:0];
        d3 = day_low[7:4];
        d4 = day_low[3:0];
        t0 = hour_byte[7:4];
        t1 = hour_byte[3:0];
        t2 = minute_byte[7:4];
        t3 = minute_byte[3:0];
        t4 = second_byte[7:4];
        t5 = second_byte[3:0];
        day_good  = digit_ok(d0, DIGIT_MAX_DEC) && digit_ok(d1, DIGIT_MAX_DEC)
                 && digit_ok(d2, DIGIT_MAX_DEC) && digit_ok(d3, DIGIT_MAX_DEC)
                 && digit_ok(d4, DIGIT_MAX_DEC);
        time_good = digit_ok(t0, DIGIT_MAX_HT) && digit_ok(t1, DIGIT_MAX_DEC)
                 && digit_ok(t2, DIGIT_MAX_MS) && digit_ok(t3, DIGIT_MAX_DEC)
                 && digit_ok(t4, DIGIT_MAX_MS) && digit_ok(t5, DIGIT_MAX_DEC);

        mjd1_next   = {13'd0, digit_of(d0)} * 17'd10000
                    + {13'd0, digit_of(d1)} * 17'd1000
                    + {13'd0, digit_of(d2)} * 17'd100
                    + {13'd0, digit_of(d3)} * 17'd10
                    + {13'd0, digit_of(d4)};
        hours1_next = {1'b0, digit_of(t0)} * 5'd10 + {1'b0, digit_of(t1)};
        mins1_next  = {2'b0, digit_of(t2)} * 6'd10 + {2'b0, digit_of(t3)};
        secs1_next  = {2'b0, digit_of(t4)} * 6'd10 + {2'b0, digit_of(t5)};
        count1_next = 6'(zone_byte & ZONE_COUNT_MASK);
        west1_next  = zone_byte[ZONE_WEST_BIT];

        priority if (!day_good)
            st1_next = ST_BAD_DAY;
        else if (!time_good)
            st1_next = ST_BAD_TIME;
        else if (hours1_next >= 5'(HOURS_PER_DAY))
            st1_next = ST_BEYOND_DAY;
        else if (count1_next > 6'(ZONE_COUNT_MAX))
            st1_next = ST_ZONE_RANGE;
        else
            st1_next = ST_OK;
    end

    always_comb
    begin
        logic [16:0] zmag;
        st2_next   = st1_reg;
        dday2_next = $signed({1'b0, mjd1_reg}) - $signed(18'(MJD_UNIX_EPOCH));
        tod2_next  = 17'(hours1_reg) * 17'(SECS_PER_HOUR)
                   + 17'(mins1_reg) * 17'(SECS_PER_MINUTE)
                   + 17'(secs1_reg);
        zmag       = 17'(count1_reg) * 17'(SECS_PER_COUNT);
        zone2_next = west1_reg ? -$signed(zmag) : $signed(zmag);
    end

    assign prod3_next = 35'(dday2_reg) * 35'sd86400;

    always_comb
    begin
        if (st3_reg == ST_OK)
        begin
            epoch4_next = 34'(prod3_reg + $signed({18'd0, tod3_reg}));
            zone4_next  = zone3_reg;
        end
        else
        begin
            epoch4_next = '0;
            zone4_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= in_valid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
            if (adv4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            st1_reg    <= st1_next;
            mjd1_reg   <= mjd1_next;
            hours1_reg <= hours1_next;
            mins1_reg  <= mins1_next;
            secs1_reg  <= secs1_next;
            count1_reg <= count1_next;
            west1_reg  <= west1_next;
        end
        if (adv2 && v1_reg)
        begin
            st2_reg   <= st2_next;
            dday2_reg <= dday2_next;
            tod2_reg  <= tod2_next;
            zone2_reg <= zone2_next;
        end
        if (adv3 && v2_reg)
        begin
            st3_reg   <= st2_reg;
            prod3_reg <= prod3_next;
            tod3_reg  <= tod2_reg;
            zone3_reg <= zone2_reg;
        end
        if (adv4 && v3_reg)
        begin
            st4_reg    <= st3_reg;
            epoch4_reg <= epoch4_next;
            zone4_reg  <= zone4_next;
        end
    end

    assign out_valid     = v4_reg;
    assign status        = st4_reg;
    assign epoch_seconds = epoch4_reg;
    assign zone_offset   = zone4_reg;

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (st4_reg != ST_OK) |-> (epoch4_reg == '0) && (zone4_reg == '0))
        else $error("nonzero result with error status");

    a_zone_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (st4_reg == ST_OK)
            |-> (zone4_reg <= 17'sd43200) && (zone4_reg >= -17'sd43200))
        else $error("zone offset out of range");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> v1_reg && v2_reg && v3_reg && v4_reg && out_stall)
        else $error("input stalled with a free stage");

    a_beyond_day: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && (st2_reg == ST_OK) |-> (tod2_reg < 17'(SECONDS_PER_DAY)))
        else $error("accepted time of day beyond one day");
`endif

endmodule

`default_nettype wire

FILE: dv/teletext_time_packet_decode_checker.sv
`timescale 1ns / 1ps

module teletext_time_packet_decode_checker
    import ttx_time_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic [7:0]         zone_byte,
    input  wire logic [7:0]         day_top,
    input  wire logic [7:0]         day_mid,
    input  wire logic [7:0]         day_low,
    input  wire logic [7:0]         hour_byte,
    input  wire logic [7:0]         minute_byte,
    input  wire logic [7:0]         second_byte,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic [2:0]         status,
    input  wire logic signed [33:0] epoch_seconds,
    input  wire logic signed [16:0] zone_offset,
    output int                      errors,
    output int                      pending,
    output int                      checked,
    output int                      valid_times
);

    localparam int PRINT_CAP = 40;

    typedef struct packed {
        status_t            st;
        logic signed [33:0] epoch;
        logic signed [16:0] zone;
    } decoded_time_t;

    decoded_time_t decoded_q [$];

    initial
    begin
        errors      = 0;
        pending     = 0;
        checked     = 0;
        valid_times = 0;
    end

    function automatic decoded_time_t decode_time_packet(
        input logic [7:0] zb, input logic [7:0] dt, input logic [7:0] dm,
        input logic [7:0] dl, input logic [7:0] hb, input logic [7:0] mb,
        input logic [7:0] sb);
        logic [3:0]    nib [11];
        int            dig [11];
        int            lim;
        bit            bad_day;
        bit            bad_time;
        longint        mjd;
        longint        tod;
        longint        offs;
        decoded_time_t r;
        nib = '{dt[3:0], dm[7:4], dm[3:0], dl[7:4], dl[3:0],
                hb[7:4], hb[3:0], mb[7:4], mb[3:0], sb[7:4], sb[3:0]};
        bad_day  = 1'b0;
        bad_time = 1'b0;
        for (int i = 0; i < 11; i++)
        begin
            lim = (i == 5) ? int'(DIGIT_MAX_HT) :
                  (i == 7 || i == 9) ? int'(DIGIT_MAX_MS) : int'(DIGIT_MAX_DEC);
            dig[i] = int'(nib[i]) - 1;
            if (dig[i] < 0 || dig[i] > lim)
            begin
                if (i < 5)
                    bad_day = 1'b1;
                else
                    bad_time = 1'b1;
            end
        end
        mjd = longint'(dig[0]) * 10000 + dig[1] * 1000 + dig[2] * 100 + dig[3] * 10 + dig[4];
        tod = longint'(dig[5] * 10 + dig[6]) * SECS_PER_HOUR
            + (dig[7] * 10 + dig[8]) * SECS_PER_MINUTE + dig[9] * 10 + dig[10];
        offs = longint'(zb & ZONE_COUNT_MASK) * SECS_PER_COUNT;
        r = '0;
        if (bad_day)
            r.st = ST_BAD_DAY;
        else if (bad_time)
            r.st = ST_BAD_TIME;
        else if (tod >= SECONDS_PER_DAY)
            r.st = ST_BEYOND_DAY;
        else if (offs > ZONE_LIMIT)
            r.st = ST_ZONE_RANGE;
        else
        begin
            if (zb[ZONE_WEST_BIT])
                offs = -offs;
            r.st    = ST_OK;
            r.epoch = 34'((mjd - MJD_UNIX_EPOCH) * SECONDS_PER_DAY + tod);
            r.zone  = 17'(offs);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (errors < PRINT_CAP)
            $display("%0t mismatch on result %0d, %s: got %0d, expected %0d",
                     $realtime, checked, what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        decoded_time_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (decoded_q.size() == 0)
                    report_mismatch("unrequested item", longint'(status), -1);
                else
                begin
                    want = decoded_q.pop_front();
                    if (status !== want.st)
                        report_mismatch("status", longint'(status), longint'(want.st));
                    if (epoch_seconds !== want.epoch)
                        report_mismatch("epoch_seconds", longint'(epoch_seconds),
                                        longint'(want.epoch));
                    if (zone_offset !== want.zone)
                        report_mismatch("zone_offset", longint'(zone_offset),
                                        longint'(want.zone));
                    if (want.st == ST_OK)
                        valid_times++;
                    checked++;
                end
            end
            if (in_valid && !in_stall)
                decoded_q.push_back(decode_time_packet(zone_byte, day_top, day_mid, day_low,
                                                       hour_byte, minute_byte, second_byte));
            pending = decoded_q.size();
        end
    end

endmodule

FILE: dv/teletext_time_packet_decode_test.sv
`timescale 1ns / 1ps

module teletext_time_packet_decode_test;

    import ttx_time_pkg::*;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int RANDOM_PER_PHASE = 338;
    localparam int DRAIN_CYCLES     = 10;

    typedef enum int {
        FAULT_DIGIT,
        FAULT_LATE_HOUR,
        FAULT_ZONE
    } fault_t;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_stall;
    logic [7:0]         zone_byte   = '0;
    logic [7:0]         day_top     = '0;
    logic [7:0]         day_mid     = '0;
    logic [7:0]         day_low     = '0;
    logic [7:0]         hour_byte   = '0;
    logic [7:0]         minute_byte = '0;
    logic [7:0]         second_byte = '0;
    logic               out_valid;
    logic               out_stall   = 1'b0;
    logic [2:0]         status;
    logic signed [33:0] epoch_seconds;
    logic signed [16:0] zone_offset;

    int errors;
    int pending;
    int checked;
    int valid_times;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int cycle_count   = 0;
    int sent          = 0;

    teletext_time_packet_decode u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .zone_byte     (zone_byte),
        .day_top       (day_top),
        .day_mid       (day_mid),
        .day_low       (day_low),
        .hour_byte     (hour_byte),
        .minute_byte   (minute_byte),
        .second_byte   (second_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .epoch_seconds (epoch_seconds),
        .zone_offset   (zone_offset)
    );

    teletext_time_packet_decode_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .zone_byte     (zone_byte),
        .day_top       (day_top),
        .day_mid       (day_mid),
        .day_low       (day_low),
        .hour_byte     (hour_byte),
        .minute_byte   (minute_byte),
        .second_byte   (second_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .epoch_seconds (epoch_seconds),
        .zone_offset   (zone_offset),
        .errors        (errors),
        .pending       (pending),
        .checked       (checked),
        .valid_times   (valid_times)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // stall is sampled at the falling edge, where it has settled for the next rising edge
    task automatic send_packet(input logic [7:0] z, input logic [7:0] dt, input logic [7:0] dm,
                               input logic [7:0] dl, input logic [7:0] hb,
                               input logic [7:0] mb, input logic [7:0] sb);
        bit took;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        zone_byte   <= z;
        day_top     <= dt;
        day_mid     <= dm;
        day_low     <= dl;
        hour_byte   <= hb;
        minute_byte <= mb;
        second_byte <= sb;
        took = 1'b0;
        while (!took)
        begin
            @(negedge clk);
            took = !in_stall;
            @(posedge clk);
        end
        sent++;
    endtask

    function automatic logic [7:0] two_digits(input int v);
        return {4'(v / 10 + 1), 4'(v % 10 + 1)};
    endfunction

    task automatic send_time(input logic [7:0] z, input int mjd, input int hh, input int mm,
                             input int ss);
        send_packet(z, 8'(mjd / 10000 + 1),
                    {4'(mjd / 1000 % 10 + 1), 4'(mjd / 100 % 10 + 1)},
                    two_digits(mjd % 100), two_digits(hh), two_digits(mm), two_digits(ss));
    endtask

    task automatic send_random_packet();
        logic [3:0] nib [11];
        int         mjd;
        int         hh;
        int         mm;
        int         ss;
        int         count;
        int         idx;
        int         lim;
        logic [7:0] z;
        if ($urandom_range(99) < 25)
        begin
            send_packet(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom), 8'($urandom), 8'($urandom));
            return;
        end
        mjd = $urandom_range(99999);
        if ($urandom_range(9) == 0)
            mjd = $urandom_range(40595, 40580);
        hh = $urandom_range(23);
        mm = $urandom_range(59);
        ss = $urandom_range(59);
        nib = '{4'(mjd / 10000 + 1), 4'(mjd / 1000 % 10 + 1), 4'(mjd / 100 % 10 + 1),
                4'(mjd / 10 % 10 + 1), 4'(mjd % 10 + 1), 4'(hh / 10 + 1), 4'(hh % 10 + 1),
                4'(mm / 10 + 1), 4'(mm % 10 + 1), 4'(ss / 10 + 1), 4'(ss % 10 + 1)};
        count = $urandom_range(24);
        if ($urandom_range(99) < 20)
        begin
            case (fault_t'($urandom_range(2)))
                FAULT_DIGIT:
                begin
                    idx = $urandom_range(10);
                    lim = (idx == 5) ? int'(DIGIT_MAX_HT) :
                          (idx == 7 || idx == 9) ? int'(DIGIT_MAX_MS) : int'(DIGIT_MAX_DEC);
                    nib[idx] = $urandom_range(1) ? 4'd0 : 4'($urandom_range(15, lim + 2));
                end
                FAULT_LATE_HOUR:
                begin
                    nib[5] = 4'd3;
                    nib[6] = 4'($urandom_range(10, 5));
                end
                default:
                    count = $urandom_range(31, 25);
            endcase
        end
        z = {1'($urandom), 1'($urandom), 5'(count), 1'($urandom)};
        send_packet(z, {4'($urandom), nib[0]}, {nib[1], nib[2]}, {nib[3], nib[4]},
                    {nib[5], nib[6]}, {nib[7], nib[8]}, {nib[9], nib[10]});
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes of the day count and the zone offset
        send_time(8'h00, 0, 0, 0, 0);
        send_time(8'h70, 99999, 23, 59, 59);
        send_time(8'h30, 40587, 0, 0, 0);
        send_time(8'h81, 40586, 23, 59, 59);
        send_time(8'h40, 51544, 12, 30, 45);
        send_time(8'h5E, 51544, 6, 7, 8);
        send_time(8'h32, 51544, 0, 0, 0);
        send_time(8'hFF, 51544, 0, 0, 0);
        // hours 24..29 pass the digit check, checked ahead of the offset
        send_packet(8'h02, 8'hF6, 8'h26, 8'h55, 8'h35, 8'h11, 8'h11);
        send_packet(8'h3E, 8'h06, 8'h26, 8'h55, 8'h3A, 8'h6A, 8'h6A);
        // bad day digits win over everything after them
        send_packet(8'h00, 8'h00, 8'h26, 8'h55, 8'h11, 8'h11, 8'h11);
        send_packet(8'h00, 8'h06, 8'hF6, 8'h55, 8'h11, 8'h11, 8'h11);
        send_packet(8'h3E, 8'h06, 8'h26, 8'h5B, 8'h00, 8'h11, 8'h11);
        // bad time digits, leap second among them
        send_packet(8'h00, 8'h06, 8'h26, 8'h55, 8'h41, 8'h11, 8'h11);
        send_packet(8'h3E, 8'h06, 8'h26, 8'h55, 8'h10, 8'h11, 8'h11);
        send_packet(8'h00, 8'h06, 8'h26, 8'h55, 8'h11, 8'h71, 8'h11);
        send_packet(8'h00, 8'h06, 8'h26, 8'h55, 8'h11, 8'h11, 8'h71);
        send_packet(8'h00, 8'h06, 8'h26, 8'h55, 8'h11, 8'h11, 8'h1B);
        send_packet(8'h00, 8'h06, 8'h26, 8'h55, 8'h3F, 8'h6A, 8'h6A);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 80; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 80; end
                default: begin send_idle_pct = 22; stall_pct = 22; end
            endcase
            repeat (RANDOM_PER_PHASE) send_random_packet();
        end
        in_valid <= 1'b0;

        do
            @(negedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d time packets (directed extremes plus random) over four idle/stall mixes",
                 sent);
        $display("Checked %0d results: %0d valid times, %0d rejected, %0d mismatches",
                 checked, valid_times, checked - valid_times, errors);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
